FILE: rtl/blm_pkg.sv
// Shared types, widths and constants for the battery level monitor.
package blm_pkg;

  localparam int TICK_W      = 8;
  localparam int FSC_W       = 10;
  localparam int THR_W       = 8;
  localparam int SMP_W       = 10;
  localparam int ACC_W       = 16;
  localparam int TALLY_W     = 6;
  localparam int LEVEL_W     = 8;
  localparam int CFG_W       = 10;
  localparam int CFG_IDX_W   = 3;
  localparam int PCT_SCALE   = 100;
  // acc * 100 fits in 23 bits
  localparam int PROD_W      = ACC_W + 7;
  // shifted divisor: full scale << 7
  localparam int DSH_W       = FSC_W + LEVEL_W - 1;
  localparam int LEVEL_STEPS = LEVEL_W;
  localparam int STEP_CNT_W  = $clog2(LEVEL_STEPS + 1);

  localparam logic [TICK_W-1:0] POLL_PERIOD_RST = TICK_W'(10);
  localparam logic [FSC_W-1:0]  FULL_SCALE_RST  = FSC_W'(465);
  localparam logic [THR_W-1:0]  LOW_THR_RST     = THR_W'(20);
  localparam logic [THR_W-1:0]  EMPTY_THR_RST   = THR_W'(5);
  localparam logic [LEVEL_W-1:0] LEVEL_MAX      = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_POLL_PERIOD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_THR   = CFG_IDX_W'(3);

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_SAMPLE = 2'd1,
    REQ_START  = 2'd2,
    REQ_STOP   = 2'd3
  } req_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CHECK,
    ST_DIVIDE,
    ST_APPLY,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic check;
    logic div_step;
    logic apply;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic need_level;
    logic need_mean;
    logic level_sat;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/blm_if.sv
// Request and result channel interfaces of the battery level monitor.
interface blm_req_if
  import blm_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [1:0]       req_type;
  logic [SMP_W-1:0] sample;

  modport source (output valid, req_type, sample, input ready);
  modport sink   (input valid, req_type, sample, output ready);
endinterface

interface blm_res_if
  import blm_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level_percent;
  logic               low_warning;
  logic               start_sampling;
  logic               mean_ready;

  modport source (output valid, level_percent, low_warning, start_sampling, mean_ready,
                  input ready);
  modport sink   (input valid, level_percent, low_warning, start_sampling, mean_ready,
                  output ready);
endinterface

FILE: rtl/blm_ctrl.sv
// Sequencer: walks one word through update, divide and result hand-off.
module blm_ctrl
  import blm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    req_fire,
  input  status_t status,
  output logic    req_ready,
  output cmd_t    cmd
);

  state_t                state, state_next;
  logic [STEP_CNT_W-1:0] step_cnt, step_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_fire) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (status.need_level)     state_next = ST_CHECK;
        else if (status.need_mean) state_next = ST_APPLY;
        else                       state_next = ST_FINISH;
      end
      ST_CHECK: begin
        state_next = status.level_sat ? ST_APPLY : ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (step_cnt == STEP_CNT_W'(1)) state_next = ST_APPLY;
      end
      ST_APPLY: state_next = ST_FINISH;
      ST_FINISH: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // step counter for the level divider
  always_comb begin
    step_cnt_next = step_cnt;
    if (state == ST_CHECK && !status.level_sat) begin
      step_cnt_next = STEP_CNT_W'(LEVEL_STEPS);
    end else if (state == ST_DIVIDE) begin
      step_cnt_next = step_cnt - STEP_CNT_W'(1);
    end
  end

  always_comb begin
    req_ready    = (state == ST_IDLE);
    cmd.capture  = req_fire;
    cmd.exec     = (state == ST_EXEC);
    cmd.check    = (state == ST_CHECK);
    cmd.div_step = (state == ST_DIVIDE);
    cmd.apply    = (state == ST_APPLY);
    cmd.emit     = (state == ST_FINISH) && status.out_free;
  end

endmodule

FILE: rtl/blm_dp.sv
// Datapath: settings, monitor state, restoring divider and result registers.
module blm_dp
  import blm_pkg::*;
#(
  parameter int BURST_SAMPLES = 32,
  parameter int ADC_BITS      = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output status_t              status,
  input  logic [1:0]           req_type,
  input  logic [SMP_W-1:0]     sample,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 res_ready,
  output logic                 res_valid,
  output logic [LEVEL_W-1:0]   level_percent,
  output logic                 low_warning,
  output logic                 start_sampling,
  output logic                 mean_ready
);

  localparam logic [SMP_W-1:0] SAMPLE_MASK =
    (ADC_BITS >= SMP_W) ? {SMP_W{1'b1}} : SMP_W'((1 << ADC_BITS) - 1);
  localparam logic [TALLY_W:0] BURST_N = (TALLY_W + 1)'(BURST_SAMPLES);
  // burst mean by reciprocal multiply, exact for any 16-bit sum
  localparam int MEAN_SHIFT = ACC_W + $clog2(BURST_SAMPLES);
  localparam int MPROD_W    = 2 * ACC_W + 1;
  localparam logic [ACC_W:0] MEAN_RECIP = (ACC_W + 1)'(
    ((64'd1 << MEAN_SHIFT) + 64'(BURST_SAMPLES) - 64'd1) / 64'(BURST_SAMPLES));

  // settings
  logic [TICK_W-1:0] poll_period;
  logic [FSC_W-1:0]  full_scale;
  logic [THR_W-1:0]  low_thr;
  logic [THR_W-1:0]  empty_thr;

  // monitor state
  logic [TICK_W-1:0]  tick_count;
  logic               running;
  logic [ACC_W-1:0]   acc;
  logic [TALLY_W-1:0] tally;

  // captured word
  req_kind_t        item_kind;
  logic [SMP_W-1:0] item_sample;

  // divider
  logic [PROD_W-1:0]  rem;
  logic [DSH_W-1:0]   dsh;
  logic [LEVEL_W-1:0] quot;

  // pending result
  logic [LEVEL_W-1:0] r_level;
  logic               r_warn;
  logic               r_go;
  logic               r_ready;

  logic [TICK_W:0]      tick_inc;
  logic [TICK_W:0]      period;
  logic                 tick_wrap;
  logic [SMP_W-1:0]     smp_masked;
  logic [ACC_W:0]       sum;
  logic [ACC_W-1:0]     sum_sat;
  logic [TALLY_W:0]     tally_inc;
  logic                 burst_open;
  logic [PROD_W-1:0]    level_limit;
  logic                 div_fit;
  logic [PROD_W-1:0]    rem_sub;
  logic [MPROD_W-1:0]   mean_prod;
  logic [ACC_W-1:0]     mean;
  logic [LEVEL_W-1:0]   level;
  logic                 level_nz;
  logic                 warn;
  logic                 halt;

  always_comb begin
    tick_inc    = {1'b0, tick_count} + (TICK_W + 1)'(1);
    period      = (poll_period == '0) ? (TICK_W + 1)'(256) : {1'b0, poll_period};
    tick_wrap   = (tick_inc >= period);
    smp_masked  = item_sample & SAMPLE_MASK;
    sum         = {1'b0, acc} + (ACC_W + 1)'(smp_masked);
    sum_sat     = sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
    tally_inc   = {1'b0, tally} + (TALLY_W + 1)'(1);
    burst_open  = ({1'b0, tally} < BURST_N);
    level_limit = PROD_W'({full_scale, {LEVEL_W{1'b0}}});
    div_fit     = (rem >= PROD_W'(dsh));
    rem_sub     = rem - PROD_W'(dsh);
    mean_prod   = MPROD_W'(acc) * MPROD_W'(MEAN_RECIP);
    mean        = ACC_W'(mean_prod >> MEAN_SHIFT);
    level       = quot;
    level_nz    = (level != '0);
    warn        = level_nz && (level < low_thr);
    halt        = level_nz && (level < empty_thr);

    status.need_level = (item_kind == REQ_TICK) && tick_wrap && running;
    status.need_mean  = (item_kind == REQ_SAMPLE) && burst_open && (tally_inc == BURST_N);
    status.level_sat  = (rem >= level_limit);
    status.out_free   = !res_valid || res_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_period <= POLL_PERIOD_RST;
      full_scale  <= FULL_SCALE_RST;
      low_thr     <= LOW_THR_RST;
      empty_thr   <= EMPTY_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POLL_PERIOD: poll_period <= cfg_data[TICK_W-1:0];
        CFG_FULL_SCALE:  full_scale  <= cfg_data[FSC_W-1:0];
        CFG_LOW_THR:     low_thr     <= cfg_data[THR_W-1:0];
        CFG_EMPTY_THR:   empty_thr   <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_kind   <= req_kind_t'(req_type);
      item_sample <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      running    <= 1'b0;
      acc        <= '0;
      tally      <= '0;
    end else if (cmd.exec) begin
      unique case (item_kind)
        REQ_TICK: tick_count <= tick_wrap ? '0 : tick_inc[TICK_W-1:0];
        REQ_SAMPLE: begin
          if (burst_open) begin
            acc   <= sum_sat;
            tally <= tally_inc[TALLY_W-1:0];
          end
        end
        REQ_START: begin
          if (!running) begin
            acc        <= '0;
            tick_count <= '0;
            running    <= 1'b1;
          end
        end
        REQ_STOP: running <= 1'b0;
        default: ;
      endcase
    end else if (cmd.apply) begin
      if (item_kind == REQ_TICK) begin
        if (!halt) begin
          acc   <= '0;
          tally <= '0;
        end
      end else begin
        acc <= mean;
      end
    end
  end

  // restoring divider for the level, one quotient bit per step
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rem <= PROD_W'(acc) * PROD_W'(PCT_SCALE);
    end else if (cmd.check) begin
      if (status.level_sat) begin
        quot <= LEVEL_MAX;
      end else begin
        dsh  <= DSH_W'(full_scale) << (LEVEL_STEPS - 1);
        quot <= '0;
      end
    end else if (cmd.div_step) begin
      if (div_fit) rem <= rem_sub;
      quot <= {quot[LEVEL_W-2:0], div_fit};
      dsh  <= dsh >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      r_level <= '0;
      r_warn  <= 1'b0;
      r_go    <= 1'b0;
      r_ready <= 1'b0;
    end else if (cmd.apply) begin
      if (item_kind == REQ_TICK) begin
        r_level <= level;
        r_warn  <= warn;
        r_go    <= !halt;
      end else begin
        r_ready <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      level_percent  <= r_level;
      low_warning    <= r_warn;
      start_sampling <= r_go;
      mean_ready     <= r_ready;
    end
  end

endmodule

FILE: rtl/battery_level_monitor.sv
// Battery level monitor: poll timer, burst averaging and percent level check.
// Each word runs an update step; a tick that ends a poll period while running then takes a saturation
//   check, 8 divider steps unless saturated, and an apply step; the sample closing a burst takes an apply step.
// Flow: one word in flight; the next is taken the cycle after the result register loads,
//   and a waiting result stalls the next.
// Reset (synchronous, active high): settings to defaults, monitor state and handshakes cleared.
module battery_level_monitor
  import blm_pkg::*;
#(
  parameter int BURST_SAMPLES = 32,
  parameter int ADC_BITS      = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  blm_req_if.sink              req,
  blm_res_if.source            res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // Controller and datapath talk only through these two bundles.
  cmd_t    cmd;
  status_t status;
  logic    req_ready;
  logic    req_fire;

  // A word is taken only in idle; the datapath latches it on the same edge.
  assign req_fire  = req.valid && req_ready;
  assign req.ready = req_ready;

  // Sequencer: update step, optional saturation check and divide, optional apply, then result hand-off.
  blm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_fire  (req_fire),
    .status    (status),
    .req_ready (req_ready),
    .cmd       (cmd)
  );

  // Datapath: settings, tick counter, accumulator, level divider and output register.
  // The level divide is acc*100 / full scale with a first compare against
  // full_scale << 8 standing in for the saturation to 255; the burst mean
  // is a single reciprocal multiply by the burst size.
  blm_dp #(
    .BURST_SAMPLES (BURST_SAMPLES),
    .ADC_BITS      (ADC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .req_type       (req.req_type),
    .sample         (req.sample),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .res_ready      (res.ready),
    .res_valid      (res.valid),
    .level_percent  (res.level_percent),
    .low_warning    (res.low_warning),
    .start_sampling (res.start_sampling),
    .mean_ready     (res.mean_ready)
  );

endmodule

FILE: rtl/blm_checker.sv
// Port-level checks for the battery level monitor, bound to the top level.
module blm_checker
  import blm_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               res_valid,
  input logic               res_ready,
  input logic [LEVEL_W-1:0] level_percent,
  input logic               low_warning,
  input logic               start_sampling,
  input logic               mean_ready
);

  // one word at a time: no accept on the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("word accepted while previous one still in work");

  // a result is either a poll result or a burst completion, never both
  a_poll_or_mean: assert property (@(posedge clk) disable iff (rst)
    (res_valid && mean_ready) |-> (!start_sampling && !low_warning && level_percent == '0))
    else $error("burst completion mixed with poll result");

  // a warning comes only with a nonzero level
  a_warn_level: assert property (@(posedge clk) disable iff (rst)
    (res_valid && low_warning) |-> (level_percent != '0))
    else $error("low warning without a level");

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(level_percent) &&
      $stable(low_warning) && $stable(start_sampling) && $stable(mean_ready)))
    else $error("stalled result changed");

endmodule

bind battery_level_monitor blm_checker u_blm_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .level_percent  (res.level_percent),
  .low_warning    (res.low_warning),
  .start_sampling (res.start_sampling),
  .mean_ready     (res.mean_ready)
);
